>>> rtl/iqss_pkg.sv
// ============================================================================
// iqss_pkg
// Shared types and codes for the input-queued switch scheduler: the command
// passed from the front end to the scheduler and the result beat format.
// ============================================================================
package iqss_pkg;

  localparam int PORT_W    = 2;
  localparam int TAG_W     = 8;
  localparam int BACKLOG_W = 7;
  localparam int SLOT_W    = 16;

  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    EV_XFER      = 2'd0,
    EV_HOL_BLOCK = 2'd1,
    EV_SUMMARY   = 2'd2,
    EV_DROP      = 2'd3
  } event_t;

  typedef struct packed {
    logic              is_tick;
    logic              bad_port;
    logic [PORT_W-1:0] src;
    logic [PORT_W-1:0] dst;
    logic [TAG_W-1:0]  tag;
  } cmd_t;

  typedef struct packed {
    event_t               ev;
    logic [PORT_W-1:0]    in_port;
    logic [PORT_W-1:0]    out_port;
    logic [TAG_W-1:0]     tag;
    logic [BACKLOG_W-1:0] backlog;
    logic [SLOT_W-1:0]    slot;
    logic                 last;
  } result_t;

endpackage

>>> rtl/input_queued_switch_scheduler_core.sv
// ============================================================================
// input_queued_switch_scheduler_core
// Input-queued crossbar scheduler with one FIFO per input and fixed-priority
// output arbitration, wrapped as a queue-in / queue-out block.
// ============================================================================
//
//  channel  | handshake            | beat contents
//  ---------+----------------------+------------------------------------------
//  input    | push / full          | kind, source_port, dest_port, packet_tag
//  result   | empty / pop          | event_res, in_port, out_port, tag_out,
//           |                      | backlog, slot_number, last
//
//  Sequence: an arrival is enqueued, or dropped with a drop beat. A tick launches
//  the scan, then runs the transfer scan (memory read, then arbitrate, for each
//  input), the head-of-line scan (memory read, then a check for each eligible
//  input), and the summary. The queue memory has a single read port, so the
//  scan reads one input's entry at a time.
//  Reset: rst clears pointers, counts, backlog and the slot counter; the queue
//  memory itself is never cleared and only occupied entries are used.
//  Stalls: a two-entry command queue takes input beats while the scheduler
//  works; a four-entry result queue lets the scan run ahead of pop, and the
//  scan holds whenever it has a beat to push and that queue is full.
//
module input_queued_switch_scheduler_core import iqss_pkg::*; #(
  parameter int NUM_PORTS   = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 kind,
  input  logic [PORT_W-1:0]    source_port,
  input  logic [PORT_W-1:0]    dest_port,
  input  logic [TAG_W-1:0]     packet_tag,
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           event_res,
  output logic [PORT_W-1:0]    in_port,
  output logic [PORT_W-1:0]    out_port,
  output logic [TAG_W-1:0]     tag_out,
  output logic [BACKLOG_W-1:0] backlog,
  output logic [SLOT_W-1:0]    slot_number,
  output logic                 last
);

  cmd_t    cmd;
  logic    cmd_valid;
  logic    cmd_pop;
  result_t res;
  logic    res_push;
  logic    res_full;
  result_t res_head;

  // Front: classify arrivals and ticks, queue them ahead of the scheduler.
  iqss_front #(
    .NUM_PORTS (NUM_PORTS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .source_port (source_port),
    .dest_port   (dest_port),
    .packet_tag  (packet_tag),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  // Back: per-input FIFOs and the slot scan.
  iqss_sched #(
    .NUM_PORTS   (NUM_PORTS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_sched (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  // Hold result beats until the consumer pops them.
  iqss_res_fifo u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr_en (res_push),
    .din   (res),
    .full  (res_full),
    .empty (empty),
    .dout  (res_head),
    .pop   (pop)
  );

  assign event_res   = res_head.ev;
  assign in_port     = res_head.in_port;
  assign out_port    = res_head.out_port;
  assign tag_out     = res_head.tag;
  assign backlog     = res_head.backlog;
  assign slot_number = res_head.slot;
  assign last        = res_head.last;

endmodule

>>> rtl/iqss_front.sv
// ============================================================================
// iqss_front
// Input side: classify each beat (arrival or tick, port range check) and
// hold it in a two-entry command queue in front of the scheduler.
// ============================================================================
module iqss_front import iqss_pkg::*; #(
  parameter int NUM_PORTS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              kind,
  input  logic [PORT_W-1:0] source_port,
  input  logic [PORT_W-1:0] dest_port,
  input  logic [TAG_W-1:0]  packet_tag,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_pop
);

  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);

  cmd_t             q [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr;
  logic [CQ_AW-1:0] rd_ptr;
  logic [CQ_AW:0]   count;
  cmd_t             cmd_in;
  logic             accept;
  logic             take;

  always_comb begin
    cmd_in.is_tick  = (kind == KIND_TICK);
    cmd_in.bad_port = (32'(source_port) >= NUM_PORTS) || (32'(dest_port) >= NUM_PORTS);
    cmd_in.src      = source_port;
    cmd_in.dst      = dest_port;
    cmd_in.tag      = packet_tag;
  end

  assign full      = (count == (CQ_AW+1)'(CQ_DEPTH));
  assign accept    = push && !full;
  assign cmd_valid = (count != '0);
  assign take      = cmd_pop && cmd_valid;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (accept && !take) begin
        count <= count + 1'b1;
      end else if (take && !accept) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/iqss_sched.sv
// ============================================================================
// iqss_sched
// Back end: per-input packet FIFOs in one memory, arrival enqueue and drop,
// and the per-slot scan (transfers, then head-of-line checks, then summary).
// ============================================================================
module iqss_sched import iqss_pkg::*; #(
  parameter int NUM_PORTS   = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_pop,
  output logic    res_push,
  output result_t res,
  input  logic    res_full
);

  localparam int PW = $clog2(NUM_PORTS);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = $clog2(NUM_PORTS * QUEUE_DEPTH + 1);
  localparam int EW = PW + TAG_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XFER_RD,
    ST_XFER_CHK,
    ST_HOL_RD,
    ST_HOL_CHK,
    ST_SUMMARY
  } state_t;

  state_t               state;
  logic [PW-1:0]        p;
  logic [NUM_PORTS-1:0] busy;
  logic [NUM_PORTS-1:0] won;
  logic [QW-1:0]        head [NUM_PORTS];
  logic [QW-1:0]        tail [NUM_PORTS];
  logic [CW-1:0]        count [NUM_PORTS];
  logic [TW-1:0]        total;
  logic [SLOT_W-1:0]    slot;

  logic [EW-1:0]        mem [NUM_PORTS][QUEUE_DEPTH];
  logic [EW-1:0]        rd_entry;
  logic [QW-1:0]        rd_ptr;

  logic [PW-1:0]        pi;
  logic [PW-1:0]        dest_rd;
  logic [TAG_BITS-1:0]  tag_rd;
  logic                 q_full;
  logic                 last_p;
  logic                 head_wins;
  logic                 hol_eligible;
  logic                 hol_emit;
  logic                 do_push;
  logic                 do_pop;

  function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] v);
    return (v == QW'(QUEUE_DEPTH - 1)) ? '0 : v + 1'b1;
  endfunction

  // One port index addresses the per-input queue state: the arrival's source
  // while idle (input 0 for a bad port), the scan position otherwise.
  always_comb begin
    if (state == ST_IDLE) begin
      pi = cmd.bad_port ? '0 : PW'(cmd.src);
    end else begin
      pi = p;
    end
  end

  // Keep addressing the second entry while a head-of-line beat waits.
  assign rd_ptr       = (state == ST_HOL_RD || state == ST_HOL_CHK) ? ptr_inc(head[pi])
                                                                    : head[pi];
  assign dest_rd      = rd_entry[EW-1:TAG_BITS];
  assign tag_rd       = rd_entry[TAG_BITS-1:0];
  assign q_full       = (count[pi] >= CW'(QUEUE_DEPTH));
  assign last_p       = (p == PW'(NUM_PORTS - 1));
  assign head_wins    = (count[pi] != '0) && !busy[dest_rd];
  assign hol_eligible = !won[p] && (count[pi] > CW'(1));
  assign hol_emit     = !busy[dest_rd];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[pi][tail[pi]] <= {PW'(cmd.dst), TAG_BITS'(cmd.tag)};
    end
    rd_entry <= mem[pi][rd_ptr];
  end

  always_comb begin
    res_push = 1'b0;
    res      = '0;
    res.slot = slot;
    cmd_pop  = 1'b0;
    do_push  = 1'b0;
    do_pop   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && !cmd.is_tick) begin
          if (cmd.bad_port || q_full) begin
            if (!res_full) begin
              res_push     = 1'b1;
              res.ev       = EV_DROP;
              res.in_port  = cmd.src;
              res.out_port = cmd.dst;
              res.tag      = TAG_W'(TAG_BITS'(cmd.tag));
              res.backlog  = BACKLOG_W'(total);
              res.last     = 1'b1;
              cmd_pop      = 1'b1;
            end
          end else begin
            do_push = 1'b1;
            cmd_pop = 1'b1;
          end
        end
      end
      ST_XFER_CHK: begin
        if (head_wins && !res_full) begin
          res_push     = 1'b1;
          res.ev       = EV_XFER;
          res.in_port  = PORT_W'(p);
          res.out_port = PORT_W'(dest_rd);
          res.tag      = TAG_W'(tag_rd);
          do_pop       = 1'b1;
        end
      end
      ST_HOL_CHK: begin
        if (hol_emit && !res_full) begin
          res_push     = 1'b1;
          res.ev       = EV_HOL_BLOCK;
          res.in_port  = PORT_W'(p);
          res.out_port = PORT_W'(dest_rd);
          res.tag      = TAG_W'(tag_rd);
        end
      end
      ST_SUMMARY: begin
        if (!res_full) begin
          res_push    = 1'b1;
          res.ev      = EV_SUMMARY;
          res.backlog = BACKLOG_W'(total);
          res.last    = 1'b1;
          cmd_pop     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      p     <= '0;
      busy  <= '0;
      won   <= '0;
      total <= '0;
      slot  <= '0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      if (do_push) begin
        tail[pi]  <= ptr_inc(tail[pi]);
        count[pi] <= count[pi] + 1'b1;
        total     <= total + 1'b1;
      end
      if (do_pop) begin
        head[pi]      <= ptr_inc(head[pi]);
        count[pi]     <= count[pi] - 1'b1;
        total         <= total - 1'b1;
        busy[dest_rd] <= 1'b1;
        won[p]        <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid && cmd.is_tick) begin
            state <= ST_XFER_RD;
            p     <= '0;
            busy  <= '0;
            won   <= '0;
          end
        end
        ST_XFER_RD: begin
          state <= ST_XFER_CHK;
        end
        ST_XFER_CHK: begin
          if (!head_wins || !res_full) begin
            if (last_p) begin
              p     <= '0;
              state <= ST_HOL_RD;
            end else begin
              p     <= p + 1'b1;
              state <= ST_XFER_RD;
            end
          end
        end
        ST_HOL_RD: begin
          if (hol_eligible) begin
            state <= ST_HOL_CHK;
          end else if (last_p) begin
            state <= ST_SUMMARY;
          end else begin
            p <= p + 1'b1;
          end
        end
        ST_HOL_CHK: begin
          if (!hol_emit || !res_full) begin
            if (last_p) begin
              state <= ST_SUMMARY;
            end else begin
              p     <= p + 1'b1;
              state <= ST_HOL_RD;
            end
          end
        end
        ST_SUMMARY: begin
          if (!res_full) begin
            slot  <= slot + 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  a_wins_match_outputs: assert property (@(posedge clk) disable iff (rst)
    $countones(won) == $countones(busy))
    else $error("winning inputs and claimed outputs disagree");

  a_cmd_pop_state: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> ((state == ST_IDLE && !cmd.is_tick) || state == ST_SUMMARY))
    else $error("command retired outside arrival or summary");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count[p] <= CW'(QUEUE_DEPTH))
    else $error("input queue count beyond depth");

  a_slot_advance: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.ev == EV_SUMMARY) |=> (slot == $past(slot) + 1'b1))
    else $error("slot counter did not advance after summary");

endmodule

>>> rtl/iqss_res_fifo.sv
// ============================================================================
// iqss_res_fifo
// Result queue: holds result beats from the scheduler until the consumer
// pops them, so the scan keeps going while the output side stalls until it fills.
// ============================================================================
module iqss_res_fifo import iqss_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  result_t din,
  output logic    full,
  output logic    empty,
  output result_t dout,
  input  logic    pop
);

  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  result_t          q [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr;
  logic [RQ_AW-1:0] rd_ptr;
  logic [RQ_AW:0]   count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == (RQ_AW+1)'(RQ_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = pop && !empty;
  assign dout  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
